// ===== rtl/rws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_pkg
// Shared types, constants and the control store of the roulette wheel
// selector.
// ----------------------------------------------------------------------------
package rws_pkg;

  localparam int unsigned OP_W               = 2;
  localparam int unsigned WEIGHT_W           = 16;
  localparam int unsigned RND_W              = 31;
  localparam int unsigned INDEX_W            = 6;
  localparam int unsigned DEFAULT_MAX_MEMBERS = 64;
  localparam int unsigned DIV_CNT_W          = $clog2(RND_W);

  // Operation codes carried by an input item.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

  // Steps of the control program.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_WALK_INIT,
    ST_WALK_STEP,
    ST_EMIT
  } step_e;

  // Datapath actions selected by a control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_WALK_INIT,
    ACT_WALK_STEP,
    ACT_EMIT
  } act_e;

  // Branch conditions tested by a control word.
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_SELECT,
    C_EMPTY,
    C_DIV_MORE,
    C_WALK_MORE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic  in_rdy;
    act_e  act;
    cond_e cond;
    step_e tgt_t;
    step_e tgt_f;
  } ctrl_t;

  // Control store: one word per step, branch to tgt_t when the condition
  // holds and to tgt_f otherwise.
  function automatic ctrl_t ucode(input step_e step);
    ctrl_t w;
    unique case (step)
      ST_IDLE:      w = '{1'b1, ACT_ACCEPT,    C_SELECT,    ST_DIV_INIT,  ST_IDLE};
      ST_DIV_INIT:  w = '{1'b0, ACT_DIV_INIT,  C_EMPTY,     ST_EMIT,      ST_DIV_STEP};
      ST_DIV_STEP:  w = '{1'b0, ACT_DIV_STEP,  C_DIV_MORE,  ST_DIV_STEP,  ST_WALK_INIT};
      ST_WALK_INIT: w = '{1'b0, ACT_WALK_INIT, C_ALWAYS,    ST_WALK_STEP, ST_WALK_STEP};
      ST_WALK_STEP: w = '{1'b0, ACT_WALK_STEP, C_WALK_MORE, ST_WALK_STEP, ST_EMIT};
      ST_EMIT:      w = '{1'b0, ACT_EMIT,      C_OUT_FREE,  ST_IDLE,      ST_EMIT};
      default:      w = '{1'b0, ACT_NONE,      C_ALWAYS,    ST_IDLE,      ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/rws_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_in_if
// Input channel of the roulette wheel selector: valid, ready and one item.
// ----------------------------------------------------------------------------
interface rws_in_if import rws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [WEIGHT_W-1:0] weight;
  logic [RND_W-1:0]    random_word;

  modport source (output valid, op, weight, random_word, input ready);
  modport sink   (input valid, op, weight, random_word, output ready);
endinterface

// ===== rtl/rws_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_out_if
// Result channel of the roulette wheel selector: valid, ready and one item.
// ----------------------------------------------------------------------------
interface rws_out_if import rws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] index;
  logic               status;

  modport source (output valid, index, status, input ready);
  modport sink   (input valid, index, status, output ready);
endinterface

// ===== rtl/rws_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rws_ram
// Generic RAM with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module rws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/roulette_wheel_selector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportional selector over a store of integer weights.
// ----------------------------------------------------------------------------
// Items arrive on in_i (valid/ready) and carry an operation: clear the store,
// append one weight, or select with a random word. Only a select gives a
// result on out_o, which holds the chosen index and a status bit that is set
// when the store is empty.
// A short control program steps a plain datapath. Clear and append finish in
// the cycle of acceptance, so they can follow each other every cycle. A select
// reduces the random word modulo (total + 1) by restoring division, one bit a
// cycle, then walks the weight RAM one entry a cycle. The result is registered
// once the walk ends and the output register is free; a select on an empty
// store skips the division and the walk and goes straight to its result.
// The next item is taken as soon as the result is in the output register.
// If the receiver stalls while a result is waiting, a following select holds
// in its final step until the register frees; items ahead of it go on, none after it.
// Reset empties the store and the output register; the RAM contents are not
// cleared, as only entries below the fill count are ever used.
// ----------------------------------------------------------------------------
module roulette_wheel_selector import rws_pkg::*; #(
  parameter int unsigned MAX_MEMBERS = DEFAULT_MAX_MEMBERS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rws_in_if.sink   in_i,
  rws_out_if.source out_o
);

  localparam int unsigned AW      = $clog2(MAX_MEMBERS);
  localparam int unsigned CW      = $clog2(MAX_MEMBERS + 1);
  localparam int unsigned TOTAL_W = WEIGHT_W + AW;

  step_e               upc_q, upc_d;
  ctrl_t               cw;
  logic                cond;

  logic [CW-1:0]       cnt_q, cnt_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic [TOTAL_W-1:0]  rem_q, rem_d;
  logic [RND_W-1:0]    shift_q, shift_d;
  logic [DIV_CNT_W-1:0] bitcnt_q, bitcnt_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [TOTAL_W-1:0]  cum_q, cum_d;

  logic                out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]  out_index_q, out_index_d;
  logic                out_status_q, out_status_d;

  logic                accept;
  logic                full;
  logic                empty;
  logic [TOTAL_W:0]    divisor;
  logic [TOTAL_W:0]    rem_sh;
  logic [TOTAL_W-1:0]  cum_next;
  logic                walk_more;
  logic                out_free;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [WEIGHT_W-1:0] ram_rdata;

  rws_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_MEMBERS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (in_i.weight),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cw       = ucode(upc_q);
  assign accept   = cw.in_rdy && in_i.valid;
  assign full     = (cnt_q == CW'(MAX_MEMBERS));
  assign empty    = (cnt_q == '0);
  assign divisor  = {1'b0, total_q} + (TOTAL_W+1)'(1);
  assign rem_sh   = {rem_q, shift_q[RND_W-1]};
  assign cum_next = cum_q + TOTAL_W'(ram_rdata);
  assign walk_more = (rem_q > cum_next) && ((CW'(pos_q) + CW'(1)) < cnt_q);
  assign out_free = !out_valid_q || out_o.ready;

  assign ram_we    = accept && (in_i.op == OP_APPEND) && !full;
  // The entry after the current one is fetched while the current one is summed.
  assign ram_raddr = (cw.act == ACT_WALK_STEP) ? AW'(pos_q + AW'(1)) : '0;

  // Branch condition of the current control word.
  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:    cond = 1'b1;
      C_SELECT:    cond = accept && (in_i.op == OP_SELECT);
      C_EMPTY:     cond = empty;
      C_DIV_MORE:  cond = (bitcnt_q != DIV_CNT_W'(RND_W - 1));
      C_WALK_MORE: cond = walk_more;
      C_OUT_FREE:  cond = out_free;
      default:     cond = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    upc_d = cond ? cw.tgt_t : cw.tgt_f;
  end

  // Datapath actions.
  always_comb begin
    cnt_d        = cnt_q;
    total_d      = total_q;
    rem_d        = rem_q;
    shift_d      = shift_q;
    bitcnt_d     = bitcnt_q;
    pos_d        = pos_q;
    cum_d        = cum_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_index_d  = out_index_q;
    out_status_d = out_status_q;

    unique case (cw.act)
      ACT_ACCEPT: begin
        if (accept) begin
          if (in_i.op == OP_CLEAR) begin
            cnt_d   = '0;
            total_d = '0;
          end else if (ram_we) begin
            cnt_d   = cnt_q + CW'(1);
            total_d = total_q + TOTAL_W'(in_i.weight);
          end else if (in_i.op == OP_SELECT) begin
            shift_d = in_i.random_word;
            pos_d   = '0;
          end
        end
      end
      ACT_DIV_INIT: begin
        rem_d    = '0;
        bitcnt_d = '0;
      end
      ACT_DIV_STEP: begin
        if (rem_sh >= divisor) begin
          rem_d = TOTAL_W'(rem_sh - divisor);
        end else begin
          rem_d = TOTAL_W'(rem_sh);
        end
        shift_d  = {shift_q[RND_W-2:0], 1'b0};
        bitcnt_d = bitcnt_q + DIV_CNT_W'(1);
      end
      ACT_WALK_INIT: begin
        pos_d = '0;
        cum_d = '0;
      end
      ACT_WALK_STEP: begin
        if (walk_more) begin
          pos_d = pos_q + AW'(1);
          cum_d = cum_next;
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_index_d  = empty ? '0 : INDEX_W'(pos_q);
          out_status_d = empty;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_IDLE;
      cnt_q       <= '0;
      total_q     <= '0;
      bitcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      cnt_q       <= cnt_d;
      total_q     <= total_d;
      bitcnt_q    <= bitcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    shift_q      <= shift_d;
    pos_q        <= pos_d;
    cum_q        <= cum_d;
    out_index_q  <= out_index_d;
    out_status_q <= out_status_d;
  end

  assign in_i.ready   = cw.in_rdy;
  assign out_o.valid  = out_valid_q;
  assign out_o.index  = out_index_q;
  assign out_o.status = out_status_q;

  // The fill count never passes the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(MAX_MEMBERS))
    else $error("entry count beyond store depth");

  // The partial remainder stays below the divisor throughout the division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == ST_DIV_STEP) |-> ({1'b0, rem_q} < divisor))
    else $error("partial remainder not reduced");

  // The walk only visits written entries and never sums past the total.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == ST_WALK_STEP) |-> ((CW'(pos_q) < cnt_q) && (cum_q <= total_q)))
    else $error("walk outside filled part of store");

  // An empty-store result always carries index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_index_q == '0))
    else $error("error result with nonzero index");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the roulette wheel selector.
// ----------------------------------------------------------------------------
// A short directed sequence covers the empty store, zero weights, the unused
// operation and the weight extremes. Random sequences follow: clear, a run of
// appends (now and then past a full store) and a few selections, mixed with
// stray items. A scoreboard keeps its own copy of the weight store, predicts
// every selection on acceptance and checks each result in order. Both sides
// of the block stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import rws_pkg::*;

  localparam int unsigned MEMBERS = DEFAULT_MAX_MEMBERS;
  localparam int unsigned ITEM_TARGET = 380;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [INDEX_W-1:0] slot;
    logic               status;
  } pick_t;

  class selection_scoreboard;
    logic [WEIGHT_W-1:0] weights [MEMBERS];
    int unsigned         fill;
    logic [21:0]         total;
    pick_t               picks_due [$];
    int unsigned         errors;
    int unsigned         picks_checked;
    int unsigned         empty_picks;
    int unsigned         full_picks;
    int unsigned         refused;
    int unsigned         deepest;

    function new();
      fill          = 0;
      total         = '0;
      errors        = 0;
      picks_checked = 0;
      empty_picks   = 0;
      full_picks    = 0;
      refused       = 0;
      deepest       = 0;
    endfunction

    task report(input string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Applies one accepted item to the local copy of the store and queues the
    // selection it produces, if any.
    task note_item(input logic [OP_W-1:0] op, input logic [WEIGHT_W-1:0] w,
                   input logic [RND_W-1:0] rnd);
      int unsigned target;
      int unsigned cum;
      int unsigned pos;
      pick_t       pick;
      case (op)
        OP_CLEAR: begin
          fill  = 0;
          total = '0;
        end
        OP_APPEND: begin
          if (fill < MEMBERS) begin
            weights[fill] = w;
            fill++;
            total = total + 22'(w);
          end else begin
            refused++;
          end
        end
        OP_SELECT: begin
          if (fill == 0) begin
            pick.slot   = '0;
            pick.status = STATUS_EMPTY;
            empty_picks++;
          end else begin
            target = 32'(rnd) % (32'(total) + 1);
            pos    = 0;
            cum    = weights[0];
            // Zero weights past entry 0 leave the sum flat and are passed.
            while (target > cum && pos + 1 < fill) begin
              pos++;
              cum += weights[pos];
            end
            pick.slot   = INDEX_W'(pos);
            pick.status = STATUS_OK;
            if (fill == MEMBERS) full_picks++;
            if (pos > deepest) deepest = pos;
          end
          picks_due = {picks_due, pick};
        end
        default: ;
      endcase
    endtask

    task check_result(input logic [INDEX_W-1:0] slot, input logic status);
      pick_t due;
      if (picks_due.size() == 0) begin
        report($sformatf("unexpected result: index %0d status %0b", slot, status));
        return;
      end
      due = picks_due.pop_front();
      picks_checked++;
      if (slot !== due.slot)
        report($sformatf("index %0d, expected %0d", slot, due.slot));
      if (status !== due.status)
        report($sformatf("status %0b, expected %0b", status, due.status));
    endtask

    task close_out();
      while (picks_due.size() != 0) begin
        report($sformatf("no result for expected index %0d status %0b",
                         picks_due[0].slot, picks_due[0].status));
        void'(picks_due.pop_front());
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned items_sent;
  selection_scoreboard sb;

  rws_in_if  in_if ();
  rws_out_if out_if ();

  roulette_wheel_selector u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WEIGHT_W-1:0] random_weight();
    int r;
    r = $urandom_range(0, 5);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_W'($urandom_range(1, 15));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // Words that land on the ends of the wheel as well as anywhere on it.
  function automatic logic [RND_W-1:0] random_word_for(input logic [21:0] sum);
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return RND_W'(sum);
      3:       return (sum == 0) ? '0 : RND_W'(sum - 1);
      default: return RND_W'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [WEIGHT_W-1:0] w,
                           input logic [RND_W-1:0] rnd);
    int gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.op          <= op;
    in_if.weight      <= w;
    in_if.random_word <= rnd;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
    sb.note_item(op, w, rnd);
  endtask

  // Result side: ready drops for random stretches.
  initial begin
    int hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        hold--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) hold = gap_cycles();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.index, out_if.status);
  end

  initial begin
    int  kind;
    int  n;
    bit  first;
    sb = new();
    calm       = 1'b0;
    items_sent = 0;
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.op          <= OP_CLEAR;
    in_if.weight      <= '0;
    in_if.random_word <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_item(OP_SELECT, '0, '0);
    send_item(OP_SELECT, '1, '1);
    send_item(OP_UNUSED, '1, '1);
    send_item(OP_APPEND, '0, '1);
    send_item(OP_SELECT, '0, '0);
    send_item(OP_SELECT, '1, '1);
    send_item(OP_APPEND, '1, '0);
    send_item(OP_APPEND, '0, '0);
    send_item(OP_APPEND, 16'd1, '0);
    send_item(OP_SELECT, '0, 31'd65536);
    send_item(OP_SELECT, '0, 31'd65535);
    send_item(OP_SELECT, '0, 31'd1);
    send_item(OP_UNUSED, '0, '0);
    send_item(OP_SELECT, '1, 31'd65536);
    send_item(OP_CLEAR, '1, '1);
    send_item(OP_SELECT, '0, '1);
    send_item(OP_APPEND, '1, '1);
    send_item(OP_SELECT, '0, '1);

    // Random part: mostly clear, appends, then selections.
    first = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      kind = first ? 2 : $urandom_range(0, 15);
      calm = ($urandom_range(0, 4) == 0);
      if (kind == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0:       send_item(OP_UNUSED, random_weight(), RND_W'($urandom));
            1:       send_item(OP_SELECT, random_weight(), RND_W'($urandom));
            default: send_item(OP_APPEND, random_weight(), RND_W'($urandom));
          endcase
        end
      end else begin
        if (kind != 1) send_item(OP_CLEAR, random_weight(), RND_W'($urandom));
        if (first) n = MEMBERS + 3;
        else if (kind == 2) n = $urandom_range(MEMBERS - 4, MEMBERS + 6);
        else n = $urandom_range(1, 10);
        // The first sequence fills the store with the largest weight.
        repeat (n) send_item(OP_APPEND, first ? '1 : random_weight(), RND_W'($urandom));
        repeat ($urandom_range(1, 6))
          send_item(OP_SELECT, random_weight(), random_word_for(sb.total));
      end
      first = 1'b0;
    end
    in_if.valid <= 1'b0;

    while (sb.picks_due.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    sb.close_out();

    $display("Sent %0d items; checked %0d selections, %0d on an empty store and %0d on a full one.",
             items_sent, sb.picks_checked, sb.empty_picks, sb.full_picks);
    $display("Highest index picked %0d; %0d appends refused on a full store.",
             sb.deepest, sb.refused);
    if (sb.errors == 0) begin
      $display("[roulette_wheel_selector] OK");
    end else begin
      $display("[roulette_wheel_selector] ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out waiting for the block.");
    $display("[roulette_wheel_selector] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rws_pkg.sv
rtl/rws_in_if.sv
rtl/rws_out_if.sv
rtl/rws_ram.sv
rtl/roulette_wheel_selector.sv
sim/tb_top.sv
